/* rtl/core/tet_pkg.sv */
package tet_pkg;

    localparam int TIME_W    = 48;
    localparam int DP_W      = 32;
    localparam int PORT_ID_W = 16;
    localparam int S_TDATA_W = 96;
    localparam int S_TUSER_W = 3;
    localparam int M_TDATA_W = 16;
    localparam int M_TUSER_W = 3;

    typedef enum logic [1:0] {
        CMD_ADD    = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_RUN    = 2'd2
    } cmd_t;

    typedef enum logic [2:0] {
        ST_FIRED    = 3'd0,
        ST_ADDED    = 3'd1,
        ST_REMOVED  = 3'd2,
        ST_FULL     = 3'd3,
        ST_NOTFOUND = 3'd4,
        ST_NONE     = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic fire;
        logic keep;
        logic hit;
    } eval_t;

endpackage

/* rtl/core/timer_event_table.sv */
// Add: the accepted command beat moves to the finish state, which registers the result beat once the output
// is free; no new command is taken until idle again. Remove and run: one entry per cycle, while the output is free,
// passes through the entry memory read, evaluate and compacting write-back.
// A run gives one result beat per fired entry, or one none beat if nothing fired; output backpressure stalls the scan.
// Reset (synchronous, aresetn low) empties the table and clears the output;
// entry memory contents are not cleared.
module timer_event_table import tet_pkg::*; #(
    parameter int MAX_ENTRIES = 16,
    parameter int ID_WIDTH    = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,  // event_id, delay_or_period, now_ms
    input  logic [S_TUSER_W-1:0] s_tuser,  // command, repeating
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,  // fired_id
    output logic [M_TUSER_W-1:0] m_tuser,  // status
    output logic                 m_tlast
);

    localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int EW = ID_WIDTH + 1 + 2 * TIME_W;

    state_t                state_reg, state_next;
    cmd_t                  cmd_reg, cmd_next;
    logic [CW-1:0]         count_reg, count_next;
    logic [AW-1:0]         idx_reg, idx_next;
    logic [CW-1:0]         wr_ptr_reg, wr_ptr_next;
    logic [ID_WIDTH-1:0]   key_reg, key_next;
    logic [TIME_W-1:0]     now_reg, now_next;
    logic                  found_reg, found_next;
    logic                  pend_valid_reg, pend_valid_next;
    logic [ID_WIDTH-1:0]   pend_id_reg, pend_id_next;
    logic                  m_valid_reg, m_valid_next;
    status_t               m_status_reg, m_status_next;
    logic [M_TDATA_W-1:0]  m_id_reg, m_id_next;
    logic                  m_last_reg, m_last_next;

    logic [PORT_ID_W-1:0]  in_id;
    logic [DP_W-1:0]       in_dp;
    logic [TIME_W-1:0]     in_now;
    cmd_t                  in_cmd;
    logic                  in_rep;
    logic [TIME_W-1:0]     add_time;

    logic                  accept;
    logic                  out_free;
    logic                  full;
    logic                  last_idx;

    logic                  wr_en;
    logic [AW-1:0]         wr_addr;
    logic [EW-1:0]         wr_data;
    logic                  rd_en;
    logic [AW-1:0]         rd_addr;
    logic [EW-1:0]         rd_data;

    logic [ID_WIDTH-1:0]   ent_id;
    logic                  ent_periodic;
    logic [TIME_W-1:0]     ent_time;
    logic [TIME_W-1:0]     ent_last;
    eval_t                 flags;
    logic [TIME_W-1:0]     new_last;

    logic                  push;
    status_t               push_status;
    logic [M_TDATA_W-1:0]  push_id;
    logic                  push_last;

    assign in_id    = s_tdata[15:0];
    assign in_dp    = s_tdata[47:16];
    assign in_now   = s_tdata[95:48];
    assign in_cmd   = cmd_t'(s_tuser[1:0]);
    assign in_rep   = s_tuser[2];
    assign add_time = in_rep ? TIME_W'(in_dp) : in_now + TIME_W'(in_dp);

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;
    assign full     = (count_reg == CW'(MAX_ENTRIES));
    assign last_idx = ((CW'(idx_reg) + CW'(1)) == count_reg);

    assign ent_id       = rd_data[EW-1 -: ID_WIDTH];
    assign ent_periodic = rd_data[2*TIME_W];
    assign ent_time     = rd_data[2*TIME_W-1 -: TIME_W];
    assign ent_last     = rd_data[TIME_W-1:0];

    tet_entry_ram #(
        .DEPTH (MAX_ENTRIES),
        .AW    (AW),
        .W     (EW)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    tet_eval #(
        .ID_WIDTH (ID_WIDTH)
    ) u_eval (
        .cmd          (cmd_reg),
        .key_id       (key_reg),
        .now          (now_reg),
        .found        (found_reg),
        .ent_id       (ent_id),
        .ent_periodic (ent_periodic),
        .ent_time     (ent_time),
        .ent_last     (ent_last),
        .flags        (flags),
        .new_last     (new_last)
    );

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    unique case (in_cmd)
                        CMD_ADD:    state_next = S_FINISH;
                        CMD_REMOVE,
                        CMD_RUN:    state_next = (count_reg == '0) ? S_FINISH : S_SCAN;
                        default:    state_next = S_IDLE;
                    endcase
                end
            end
            S_SCAN: begin
                if (out_free && last_idx) begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        cmd_next        = cmd_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        wr_ptr_next     = wr_ptr_reg;
        key_next        = key_reg;
        now_next        = now_reg;
        found_next      = found_reg;
        pend_valid_next = pend_valid_reg;
        pend_id_next    = pend_id_reg;
        wr_en           = 1'b0;
        wr_addr         = count_reg[AW-1:0];
        wr_data         = {ID_WIDTH'(in_id), in_rep, add_time, in_now};
        rd_en           = 1'b0;
        rd_addr         = '0;
        push            = 1'b0;
        push_status     = ST_FIRED;
        push_id         = '0;
        push_last       = 1'b0;

        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    cmd_next        = in_cmd;
                    key_next        = ID_WIDTH'(in_id);
                    now_next        = in_now;
                    found_next      = 1'b0;
                    pend_valid_next = 1'b0;
                    idx_next        = '0;
                    wr_ptr_next     = '0;
                    unique case (in_cmd)
                        CMD_ADD: begin
                            // found marks a successful add
                            found_next = !full;
                            if (!full) begin
                                wr_en      = 1'b1;
                                count_next = count_reg + CW'(1);
                            end
                        end
                        CMD_REMOVE,
                        CMD_RUN: begin
                            rd_en = (count_reg != '0);
                        end
                        default: begin
                            rd_en = 1'b0;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (out_free) begin
                    // compact: kept entries go back at the write pointer
                    if (flags.keep) begin
                        wr_en       = 1'b1;
                        wr_addr     = wr_ptr_reg[AW-1:0];
                        wr_data     = {ent_id, ent_periodic, ent_time, new_last};
                        wr_ptr_next = wr_ptr_reg + CW'(1);
                    end
                    if (flags.hit) begin
                        found_next = 1'b1;
                    end
                    // hold each fired id back one beat so the final one carries last
                    if (flags.fire) begin
                        push            = pend_valid_reg;
                        push_status     = ST_FIRED;
                        push_id         = M_TDATA_W'(pend_id_reg);
                        pend_valid_next = 1'b1;
                        pend_id_next    = ent_id;
                    end
                    if (last_idx) begin
                        count_next = wr_ptr_reg + CW'(flags.keep);
                    end else begin
                        rd_en    = 1'b1;
                        rd_addr  = idx_reg + AW'(1);
                        idx_next = idx_reg + AW'(1);
                    end
                end
            end
            S_FINISH: begin
                if (out_free) begin
                    push      = 1'b1;
                    push_last = 1'b1;
                    unique case (cmd_reg)
                        CMD_ADD:    push_status = found_reg ? ST_ADDED : ST_FULL;
                        CMD_REMOVE: push_status = found_reg ? ST_REMOVED : ST_NOTFOUND;
                        default: begin
                            if (pend_valid_reg) begin
                                push_status = ST_FIRED;
                                push_id     = M_TDATA_W'(pend_id_reg);
                            end else begin
                                push_status = ST_NONE;
                            end
                        end
                    endcase
                    pend_valid_next = 1'b0;
                end
            end
            default: begin
                push = 1'b0;
            end
        endcase
    end

    always_comb begin
        m_valid_next  = m_valid_reg && !m_tready;
        m_status_next = m_status_reg;
        m_id_next     = m_id_reg;
        m_last_next   = m_last_reg;
        if (push) begin
            m_valid_next  = 1'b1;
            m_status_next = push_status;
            m_id_next     = push_id;
            m_last_next   = push_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            pend_valid_reg <= pend_valid_next;
            m_valid_reg    <= m_valid_next;
        end
        cmd_reg      <= cmd_next;
        idx_reg      <= idx_next;
        wr_ptr_reg   <= wr_ptr_next;
        key_reg      <= key_next;
        now_reg      <= now_next;
        found_reg    <= found_next;
        pend_id_reg  <= pend_id_next;
        m_status_reg <= m_status_next;
        m_id_reg     <= m_id_next;
        m_last_reg   <= m_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_id_reg;
    assign m_tuser  = m_status_reg;
    assign m_tlast  = m_last_reg;

endmodule

/* rtl/core/tet_entry_ram.sv */
module tet_entry_ram import tet_pkg::*; #(
    parameter int DEPTH = 16,
    parameter int AW    = 4,
    parameter int W     = 113
) (
    input  logic          aclk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [W-1:0]  wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [W-1:0]  rd_data
);

    logic [W-1:0] mem [DEPTH];
    logic [W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/core/tet_eval.sv */
module tet_eval import tet_pkg::*; #(
    parameter int ID_WIDTH = 16
) (
    input  cmd_t                cmd,
    input  logic [ID_WIDTH-1:0] key_id,
    input  logic [TIME_W-1:0]   now,
    input  logic                found,
    input  logic [ID_WIDTH-1:0] ent_id,
    input  logic                ent_periodic,
    input  logic [TIME_W-1:0]   ent_time,
    input  logic [TIME_W-1:0]   ent_last,
    output eval_t               flags,
    output logic [TIME_W-1:0]   new_last
);

    logic [TIME_W-1:0] elapsed;
    logic              due;

    assign elapsed = now - ent_last;
    assign due     = ent_periodic ? (elapsed >= ent_time) : (now >= ent_time);

    always_comb begin
        flags    = '{fire: 1'b0, keep: 1'b1, hit: 1'b0};
        new_last = ent_last;
        unique case (cmd)
            CMD_RUN: begin
                flags.fire = due;
                flags.keep = ent_periodic || !due;
                if (due && ent_periodic) begin
                    new_last = now;
                end
            end
            CMD_REMOVE: begin
                // only the first matching entry goes
                flags.hit  = (ent_id == key_id) && !found;
                flags.keep = !flags.hit;
            end
            default: begin
                flags = '{fire: 1'b0, keep: 1'b1, hit: 1'b0};
            end
        endcase
    end

endmodule

/* rtl/core/tet_checker.sv */
module tet_checker import tet_pkg::*; (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic [S_TDATA_W-1:0] s_tdata,
    input logic [S_TUSER_W-1:0] s_tuser,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic [M_TUSER_W-1:0] m_tuser,
    input logic                 m_tlast
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=>
            m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))
        else $error("result beat changed while stalled");

    // only fired results carry an id
    a_id_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser != ST_FIRED) |-> (m_tdata == '0))
        else $error("nonzero id on a result that did not fire");

    // every status other than fired ends its command
    a_single_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser != ST_FIRED) |-> m_tlast)
        else $error("non-fired result without last");

    // one command at a time; an unknown command code is dropped and leaves the input open
    a_one_cmd: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready &&
            (s_tuser[1:0] == CMD_ADD || s_tuser[1:0] == CMD_REMOVE ||
             s_tuser[1:0] == CMD_RUN)
            |=> !s_tready)
        else $error("command beat taken back to back");

endmodule

bind timer_event_table tet_checker u_tet_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
